// File: design/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

   // width of the chunk size accumulator and the remaining-byte counter
   localparam int SizeBits = 32;
   // width of the emitted-in-chunk counter and of dropped_count
   localparam int CntBits  = 32;

   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);

   localparam int RspDataBits = 48;

   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChLf = 8'h0A;

   typedef enum logic [1:0] {
      END_ZERO_CHUNK = 2'd0,
      END_BOUNDARY   = 2'd1,
      END_SIZE_LINE  = 2'd2,
      END_IN_DATA    = 2'd3
   } end_status_type;

   // one classified body byte as it waits in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_hex;
      logic [3:0] digit;
      logic       is_cr;
      logic       is_lf;
   } hcd_item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic         avail;
      hcd_item_type item;
   } hcd_head_type;

endpackage

// File: design/hcd_front.sv
`timescale 1ns / 1ps

module hcd_front (
   input  logic                  req_tvalid,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  req_tready,
   output logic                  push,
   output hcd_pkg::hcd_item_type push_item
);
   import hcd_pkg::*;

   logic       dig_num;
   logic       dig_low;
   logic       dig_up;
   logic [7:0] dig_raw;

   always_comb begin
      dig_num = (req_tdata >= 8'h30) && (req_tdata <= 8'h39);
      dig_low = (req_tdata >= 8'h61) && (req_tdata <= 8'h66);
      dig_up  = (req_tdata >= 8'h41) && (req_tdata <= 8'h46);
      if (dig_num) begin
         dig_raw = req_tdata - 8'h30;
      end else if (dig_low) begin
         dig_raw = req_tdata - 8'h57;
      end else begin
         dig_raw = req_tdata - 8'h37;
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_item.data   = req_tdata;
      push_item.last   = req_tlast;
      push_item.is_hex = dig_num || dig_low || dig_up;
      push_item.digit  = dig_raw[3:0];
      push_item.is_cr  = (req_tdata == ChCr);
      push_item.is_lf  = (req_tdata == ChLf);
   end

endmodule

// File: design/hcd_fifo.sv
`timescale 1ns / 1ps

module hcd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hcd_pkg::hcd_item_type push_item,
   input  logic                  pop,
   output logic                  full,
   output hcd_pkg::hcd_head_type head
);
   import hcd_pkg::*;

   hcd_item_type          mem_ff [FifoDepth];
   logic [FifoAw-1:0]     wr_ptr_ff;
   logic [FifoAw-1:0]     rd_ptr_ff;
   logic [FifoAw:0]       count_ff;
   logic [FifoAw-1:0]     wr_ptr_in;
   logic [FifoAw-1:0]     rd_ptr_in;
   logic [FifoAw:0]       count_in;

   localparam logic [FifoAw:0] DepthCnt = FifoDepth[FifoAw:0];

   assign full       = (count_ff == DepthCnt);
   assign head.avail = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/hcd_back.sv
`timescale 1ns / 1ps

module hcd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  hcd_pkg::hcd_head_type           head,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hcd_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import hcd_pkg::*;

   typedef enum logic [2:0] {
      PH_SIZE_START,
      PH_SIZE_BODY,
      PH_DATA,
      PH_TRAIL1,
      PH_TRAIL2,
      PH_DONE
   } phase_type;

   phase_type            phase_ff,   phase_in;
   logic [SizeBits-1:0]  accum_ff,   accum_in;
   logic [SizeBits-1:0]  left_ff,    left_in;
   logic [CntBits-1:0]   emitted_ff, emitted_in;
   logic                 dig_end_ff, dig_end_in;
   logic                 prev_cr_ff, prev_cr_in;
   logic                 dec_en_ff,  dec_en_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff,  rsp_byte_in;
   logic                 rsp_flag_ff,  rsp_flag_in;
   logic                 rsp_done_ff,  rsp_done_in;
   end_status_type       rsp_stat_ff,  rsp_stat_in;
   logic [CntBits-1:0]   rsp_drop_ff,  rsp_drop_in;

   hcd_item_type         it;
   logic                 take;
   logic                 emit_byte;
   end_status_type       status;
   logic [CntBits-1:0]   dropped;

   assign it   = head.item;
   assign take = head.avail && (!rsp_valid_ff || rsp_tready);
   assign pop  = take;

   always_comb begin
      phase_in   = phase_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      emitted_in = emitted_ff;
      dig_end_in = dig_end_ff;
      prev_cr_in = prev_cr_ff;
      dec_en_in  = csr_wr_en ? csr_wr_data : dec_en_ff;
      emit_byte  = 1'b0;
      status     = END_ZERO_CHUNK;
      dropped    = '0;

      if (!dec_en_ff) begin
         emit_byte = 1'b1;
         status    = END_BOUNDARY;
      end else begin
         case (phase_ff)
            PH_SIZE_START, PH_SIZE_BODY: begin
               if (prev_cr_ff && it.is_lf) begin
                  if (accum_ff == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     left_in    = accum_ff;
                     emitted_in = '0;
                     phase_in   = PH_DATA;
                  end
                  accum_in   = '0;
                  dig_end_in = 1'b0;
                  prev_cr_in = 1'b0;
               end else begin
                  phase_in = PH_SIZE_BODY;
                  if (!dig_end_ff && it.is_hex) begin
                     // low nibble is zero after the shift, so only the top nibble can overflow
                     if (accum_ff[SizeBits-1 -: 4] != 4'd0) begin
                        accum_in = '1;
                     end else begin
                        accum_in = {accum_ff[SizeBits-5:0], it.digit};
                     end
                  end else begin
                     dig_end_in = 1'b1;
                  end
                  prev_cr_in = it.is_cr;
               end
            end
            PH_DATA: begin
               emit_byte = 1'b1;
               if (emitted_ff != '1) begin
                  emitted_in = emitted_ff + 1'b1;
               end
               if (left_ff != '0) begin
                  left_in = left_ff - 1'b1;
               end
               if (left_ff[SizeBits-1:1] == '0) begin
                  phase_in = PH_TRAIL1;
               end
            end
            PH_TRAIL1: phase_in = PH_TRAIL2;
            PH_TRAIL2: phase_in = PH_SIZE_START;
            default:   phase_in = PH_DONE;
         endcase

         case (phase_in)
            PH_DONE:      status = END_ZERO_CHUNK;
            PH_SIZE_BODY: status = END_SIZE_LINE;
            PH_DATA: begin
               status  = END_IN_DATA;
               dropped = emitted_in;
            end
            default:      status = END_BOUNDARY;
         endcase
      end

      // state only moves on a popped beat; end of body starts the next one clean
      if (!take) begin
         phase_in   = phase_ff;
         accum_in   = accum_ff;
         left_in    = left_ff;
         emitted_in = emitted_ff;
         dig_end_in = dig_end_ff;
         prev_cr_in = prev_cr_ff;
      end else if (it.last) begin
         phase_in   = PH_SIZE_START;
         accum_in   = '0;
         left_in    = '0;
         emitted_in = '0;
         dig_end_in = 1'b0;
         prev_cr_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (take && (emit_byte || it.last)) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte ? it.data : 8'd0;
         rsp_flag_in  = emit_byte;
         rsp_done_in  = it.last;
         rsp_stat_in  = it.last ? status : END_ZERO_CHUNK;
         rsp_drop_in  = it.last ? dropped : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE_START;
         accum_ff     <= '0;
         left_ff      <= '0;
         emitted_ff   <= '0;
         dig_end_ff   <= 1'b0;
         prev_cr_ff   <= 1'b0;
         dec_en_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         left_ff      <= left_in;
         emitted_ff   <= emitted_in;
         dig_end_ff   <= dig_end_in;
         prev_cr_ff   <= prev_cr_in;
         dec_en_ff    <= dec_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_done_ff <= rsp_done_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tdata  = {{(RspDataBits - CntBits - 10){1'b0}}, rsp_drop_ff,
                        rsp_stat_ff, rsp_byte_ff};

endmodule

// File: design/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// a byte beat accepted on req enters the queue, is popped into the output register when that
// register is free or draining, and any result beat it yields is presented on rsp from there
// throughput: one byte per cycle sustained while rsp is not stalled; a 4-beat queue sits
// between the byte classifier and the framing state machine; an output register follows it
// reset: synchronous, active high; clears queue, framing state and output valid,
// decode_enable returns to 1
module http_chunked_body_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,    // decode_enable
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,      // in_byte
   input  logic                            req_tlast,      // is_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] out_byte, [9:8] end_status, [41:10] dropped_count, [47:42] zero
   output logic [hcd_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                            rsp_tuser,      // out_valid
   output logic                            rsp_tlast       // done_res
);
   import hcd_pkg::*;

   logic         push;
   logic         pop;
   logic         q_full;
   hcd_item_type push_item;
   hcd_head_type head;

   hcd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .req_tready (req_tready),
      .push       (push),
      .push_item  (push_item)
   );

   hcd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .head      (head)
   );

   hcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
